// File: rtl/fcba_pkg.sv
package fcba_pkg;

  localparam int unsigned DEF_ENTRIES = 2048;
  localparam int unsigned BLK_W = 16;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned BASE_W = 15;
  localparam int unsigned ACT_W = 3;
  localparam int unsigned ST_W = 2;

  localparam logic [BASE_W-1:0] RESET_BASE = 15'd6;

  localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
  localparam logic [ACT_W-1:0] ACT_EXTEND = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FREE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TRIM = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SEEK = 3'd4;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_SHORT = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [BLK_W-1:0] block;
    logic [ACT_W-1:0] action;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] blocks_moved;
    logic [BLK_W-1:0] result_block;
    logic [ST_W-1:0]  status;
  } result_t;

  function automatic logic [BLK_W-1:0] blk_off(input logic [BLK_W-1:0] b,
                                               input logic [BASE_W-1:0] base);
    return b - {1'b0, base};
  endfunction

  function automatic logic blk_ok(input logic [BLK_W-1:0] b,
                                  input logic [BASE_W-1:0] base,
                                  input logic [BLK_W:0] n);
    logic [BLK_W:0] d;
    d = {1'b0, b} - {2'b00, base};
    return (b != '0) && (d < n);
  endfunction

endpackage

// File: rtl/fat_chain_block_allocator.sv
// Channel   Direction  Word                                     Handshake
// s_axis    in         action[2:0] block[18:3] count[34:19]      tvalid/tready
// m_axis    out        status[1:0] result_block[17:2]            tvalid/tready
//                      blocks_moved[33:18]
// cfg       in         base_block[14:0]                         cfg_valid_i/cfg_ready_o
//
// Allocate steps through the start, alloc and done states for each word.
// Walks cost one table read per link; with the single table port pair, extend
// runs add, link and term states per new block, free check and write per block.
// After reset a clearing pass writes every table entry and rebuilds the free list
// before the first word is accepted; configuration writes are taken at any time.
// A finished result waits in the output register while the next word is worked on.
module fat_chain_block_allocator #(
  parameter int unsigned ENTRIES = fcba_pkg::DEF_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // action, block, count, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // status, result_block, blocks_moved, zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(ENTRIES);

  logic [fcba_pkg::BASE_W-1:0] base_q;
  fcba_pkg::item_t             item;
  fcba_pkg::result_t           res, out_q;
  logic                        res_valid, res_ready;
  logic                        out_valid_q;
  logic                        tbl_ready, wr_en;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [fcba_pkg::BLK_W-1:0]  wr_data, rd_data;

  assign item.action = s_axis_tdata[2:0];
  assign item.block  = s_axis_tdata[18:3];
  assign item.count  = s_axis_tdata[34:19];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= fcba_pkg::RESET_BASE;
    end else if (cfg_valid_i) begin
      base_q <= cfg_data_i;
    end
  end

  fcba_table #(.ENTRIES(ENTRIES)) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data),
    .ready_o   (tbl_ready)
  );

  fcba_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_i      (base_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .tbl_ready_i (tbl_ready),
    .rd_addr_o   (rd_addr),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_data_i   (rd_data)
  );

  assign res_ready = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.blocks_moved, out_q.result_block, out_q.status};

endmodule

// File: rtl/fcba_table.sv
module fcba_table #(
  parameter int unsigned ENTRIES = fcba_pkg::DEF_ENTRIES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr_i,
  input  logic [fcba_pkg::BLK_W-1:0] wr_data_i,
  output logic [fcba_pkg::BLK_W-1:0] rd_data_o,
  output logic                       ready_o
);

  localparam int unsigned AW = $clog2(ENTRIES);

  logic [fcba_pkg::BLK_W-1:0] mem [ENTRIES];
  logic [fcba_pkg::BLK_W-1:0] rd_q;
  logic                       clr_busy_q, clr_busy_d;
  logic [AW-1:0]              clr_cnt_q, clr_cnt_d;
  logic                       we;
  logic [AW-1:0]              wa;
  logic [fcba_pkg::BLK_W-1:0] wd;
  logic [fcba_pkg::BLK_W-1:0] init_val;

  // After reset every entry is written with the initial free list, one per cycle.
  always_comb begin
    if (clr_cnt_q == '0 || clr_cnt_q == AW'(ENTRIES - 1)) begin
      init_val = '0;
    end else begin
      init_val = {1'b0, fcba_pkg::RESET_BASE} + fcba_pkg::BLK_W'(clr_cnt_q)
                 + fcba_pkg::BLK_W'(1);
    end
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(ENTRIES - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    we = clr_busy_q | wr_en_i;
    wa = clr_busy_q ? clr_cnt_q : wr_addr_i;
    wd = clr_busy_q ? init_val : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // A read of the entry written in the same cycle returns the new word.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (we && wa == rd_addr_i) begin
      rd_q <= wd;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign ready_o   = ~clr_busy_q;

endmodule

// File: rtl/fcba_ctrl.sv
module fcba_ctrl #(
  parameter int unsigned ENTRIES = fcba_pkg::DEF_ENTRIES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [fcba_pkg::BASE_W-1:0] base_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  fcba_pkg::item_t             in_item_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output fcba_pkg::result_t           res_o,
  input  logic                        tbl_ready_i,
  output logic [$clog2(ENTRIES)-1:0]  rd_addr_o,
  output logic                        wr_en_o,
  output logic [$clog2(ENTRIES)-1:0]  wr_addr_o,
  output logic [fcba_pkg::BLK_W-1:0]  wr_data_o,
  input  logic [fcba_pkg::BLK_W-1:0]  rd_data_i
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned BW = fcba_pkg::BLK_W;
  localparam int unsigned CW = fcba_pkg::CNT_W;
  localparam logic [BW:0] NUM_ENTRIES = (BW + 1)'(ENTRIES);
  localparam logic [CW-1:0] MAX_STEPS = CW'(ENTRIES);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_START    = 11'b000_0000_0010,
    S_ALLOC    = 11'b000_0000_0100,
    S_EXT_WALK = 11'b000_0000_1000,
    S_EXT_ADD  = 11'b000_0001_0000,
    S_EXT_LINK = 11'b000_0010_0000,
    S_EXT_TERM = 11'b000_0100_0000,
    S_FREE_CHK = 11'b000_1000_0000,
    S_FREE_WR  = 11'b001_0000_0000,
    S_SEEK     = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_e;

  state_e                      state_q, state_d;
  logic [fcba_pkg::ACT_W-1:0]  act_q, act_d;
  logic [BW-1:0]               cur_q, cur_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [CW-1:0]               i_q, i_d;
  logic [CW-1:0]               moved_q, moved_d;
  logic [BW-1:0]               res_q, res_d;
  logic [fcba_pkg::ST_W-1:0]   st_q, st_d;
  logic [BW-1:0]               fh_q, fh_d;
  logic [BW-1:0]               rd_blk, wr_blk, rd_off, wr_off;
  logic                        v_fh, v_cur, v_rd;

  assign v_fh  = fcba_pkg::blk_ok(fh_q, base_i, NUM_ENTRIES);
  assign v_cur = fcba_pkg::blk_ok(cur_q, base_i, NUM_ENTRIES);
  assign v_rd  = fcba_pkg::blk_ok(rd_data_i, base_i, NUM_ENTRIES);

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    moved_d   = moved_q;
    res_d     = res_q;
    st_d      = st_q;
    fh_d      = fh_q;
    rd_blk    = cur_q;
    wr_blk    = cur_q;
    wr_en_o   = 1'b0;
    wr_data_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && tbl_ready_i) begin
          act_d   = in_item_i.action;
          cur_d   = in_item_i.block;
          cnt_d   = in_item_i.count;
          i_d     = '0;
          moved_d = '0;
          res_d   = '0;
          st_d    = fcba_pkg::ST_OK;
          state_d = S_START;
        end
      end
      S_START: begin
        case (act_q)
          fcba_pkg::ACT_ALLOC: begin
            rd_blk = fh_q;
            if (fh_q == '0) begin
              st_d    = fcba_pkg::ST_NO_SPACE;
              state_d = S_DONE;
            end else if (!v_fh) begin
              st_d    = fcba_pkg::ST_RANGE;
              state_d = S_DONE;
            end else begin
              cur_d   = fh_q;
              state_d = S_ALLOC;
            end
          end
          fcba_pkg::ACT_EXTEND: begin
            state_d = v_cur ? S_EXT_WALK : S_DONE;
            if (!v_cur) begin
              st_d = fcba_pkg::ST_RANGE;
            end
          end
          fcba_pkg::ACT_FREE: begin
            state_d = S_FREE_CHK;
          end
          fcba_pkg::ACT_TRIM, fcba_pkg::ACT_SEEK: begin
            state_d = v_cur ? S_SEEK : S_DONE;
            if (!v_cur) begin
              st_d = fcba_pkg::ST_RANGE;
            end
          end
          default: begin
            st_d    = fcba_pkg::ST_RANGE;
            state_d = S_DONE;
          end
        endcase
      end
      S_ALLOC: begin
        fh_d      = rd_data_i;
        wr_en_o   = 1'b1;
        wr_data_o = '0;
        res_d     = cur_q;
        moved_d   = CW'(1);
        state_d   = S_DONE;
      end
      S_EXT_WALK: begin
        if (rd_data_i == '0) begin
          i_d     = '0;
          state_d = S_EXT_ADD;
        end else if (!v_rd || i_q >= MAX_STEPS) begin
          st_d    = fcba_pkg::ST_RANGE;
          state_d = S_DONE;
        end else begin
          cur_d  = rd_data_i;
          i_d    = i_q + CW'(1);
          rd_blk = rd_data_i;
        end
      end
      S_EXT_ADD: begin
        rd_blk = fh_q;
        if (i_q == cnt_q) begin
          state_d = S_DONE;
        end else if (fh_q == '0) begin
          st_d    = fcba_pkg::ST_NO_SPACE;
          state_d = S_DONE;
        end else if (!v_fh) begin
          st_d    = fcba_pkg::ST_RANGE;
          res_d   = '0;
          state_d = S_DONE;
        end else begin
          res_d   = fh_q;
          state_d = S_EXT_LINK;
        end
      end
      S_EXT_LINK: begin
        fh_d      = rd_data_i;
        wr_en_o   = 1'b1;
        wr_data_o = res_q;
        state_d   = S_EXT_TERM;
      end
      S_EXT_TERM: begin
        wr_en_o   = 1'b1;
        wr_blk    = res_q;
        wr_data_o = '0;
        cur_d     = res_q;
        moved_d   = moved_q + CW'(1);
        i_d       = i_q + CW'(1);
        state_d   = S_EXT_ADD;
      end
      S_FREE_CHK: begin
        if (cur_q == '0) begin
          state_d = S_DONE;
        end else if (!v_cur || i_q >= MAX_STEPS) begin
          st_d    = fcba_pkg::ST_RANGE;
          res_d   = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        wr_en_o   = 1'b1;
        wr_data_o = fh_q;
        fh_d      = cur_q;
        moved_d   = moved_q + CW'(1);
        i_d       = i_q + CW'(1);
        cur_d     = rd_data_i;
        state_d   = S_FREE_CHK;
      end
      S_SEEK: begin
        if (i_q == cnt_q) begin
          res_d = cur_q;
          if (act_q == fcba_pkg::ACT_TRIM) begin
            // The read word is the rest of the chain; it is cut off and freed.
            wr_en_o   = 1'b1;
            wr_data_o = '0;
            cur_d     = rd_data_i;
            i_d       = '0;
            state_d   = S_FREE_CHK;
          end else begin
            state_d = S_DONE;
          end
        end else if (rd_data_i == '0) begin
          st_d    = fcba_pkg::ST_SHORT;
          state_d = S_DONE;
        end else if (!v_rd) begin
          st_d    = fcba_pkg::ST_RANGE;
          state_d = S_DONE;
        end else begin
          cur_d  = rd_data_i;
          i_d    = i_q + CW'(1);
          rd_blk = rd_data_i;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    rd_off = fcba_pkg::blk_off(rd_blk, base_i);
    wr_off = fcba_pkg::blk_off(wr_blk, base_i);
  end

  assign rd_addr_o = rd_off[AW-1:0];
  assign wr_addr_o = wr_off[AW-1:0];

  assign in_ready_o  = (state_q == S_IDLE) && tbl_ready_i;
  assign res_valid_o = (state_q == S_DONE);
  assign res_o.status       = st_q;
  assign res_o.result_block = res_q;
  assign res_o.blocks_moved = moved_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fh_q    <= {1'b0, fcba_pkg::RESET_BASE} + BW'(1);
    end else begin
      state_q <= state_d;
      fh_q    <= fh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    cur_q   <= cur_d;
    cnt_q   <= cnt_d;
    i_q     <= i_d;
    moved_q <= moved_d;
    res_q   <= res_d;
    st_q    <= st_d;
  end

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !wr_en_o)
    else $error("table written outside an action");

  a_accept_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> tbl_ready_i)
    else $error("word accepted during the clearing pass");

  a_range_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status == fcba_pkg::ST_RANGE
                     || res_o.status == fcba_pkg::ST_SHORT)) |-> res_o.result_block == '0)
    else $error("failed action reports a block");

  a_free_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FREE_WR) |=> fh_q == $past(cur_q))
    else $error("freed block not pushed onto the free list");

endmodule
